// ----- design/fhce_pkg.sv -----
// Shared types and constants for the float history cache encoder.
package fhce_pkg;

	// Default ring size exponent limit and the reset value of the size register.
	localparam int DEF_MAX_BUFFER_BITS = 8;
	localparam int BUFFER_BITS_RESET   = 8;
	localparam int BUFFER_BITS_MIN     = 2;

	// Width of the configuration write data.
	localparam int CFG_W = 4;

	// Float classification.
	localparam logic [30:0] ABS_INF = 31'h7f80_0000;

	// Near-match window: image minus entry lies in -0x20000..0x1ffff.
	localparam logic [31:0] NEAR_BIAS = 32'h0002_0000;
	localparam logic [31:0] NEAR_SPAN = 32'h0004_0000;

	// A zigzag delta inside the window needs 18 bits, sent as 6-bit groups.
	localparam int ZZ_W    = 18;
	localparam int GRP_W   = 6;
	localparam logic [6:0] GRP_CONT = 7'h40;

	// Token widths.
	localparam logic [5:0] RAW_BITS = 6'd32;
	localparam logic [5:0] GRP_BITS = 6'd7;

	// Result of comparing the input image with one ring entry.
	typedef struct packed {
		logic            eq;
		logic            near;
		logic [ZZ_W-1:0] zz;
	} cmp_res_t;

endpackage

// ----- design/fhce_hist.sv -----
// Ring storage: one write port and one registered read port.
module fhce_hist #(
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [31:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [31:0]   rdata
);

	logic [31:0] mem [0:(1 << AW) - 1];
	logic [31:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- design/fhce_cmp.sv -----
// Shared compare unit: float equality, near window test and zigzag delta.
module fhce_cmp (
	input  logic [31:0]         image,
	input  logic [31:0]         entry,
	output fhce_pkg::cmp_res_t  res
);
	import fhce_pkg::*;

	logic        nan_a;
	logic        nan_b;
	logic        both_zero;
	logic [31:0] diff;
	logic [31:0] biased;
	logic [31:0] zz_full;

	always_comb begin
		nan_a     = image[30:0] > ABS_INF;
		nan_b     = entry[30:0] > ABS_INF;
		both_zero = ((image[30:0] | entry[30:0]) == 31'd0);
		diff      = image - entry;
		biased    = diff + NEAR_BIAS;
		zz_full   = {diff[30:0], 1'b0} ^ {32{diff[31]}};

		res.eq   = !nan_a && !nan_b && (both_zero || (image == entry));
		res.near = biased < NEAR_SPAN;
		res.zz   = zz_full[ZZ_W-1:0];
	end

endmodule

// ----- design/float_history_cache_encoder.sv -----
// Top level of the float history cache encoder: sequencer, ring pointers and token output.
//
// The block accepts one 32-bit float image when start is high and busy is low,
// and answers with one to five tokens, each a (token_value, token_bits) pair
// shown for exactly one cycle while token_strobe is high; last marks the final
// token of a request. The receiver cannot hold tokens off, so it must take every
// strobed cycle. The ring is searched newest to oldest by a single compare unit
// that sees one entry per read/compare state pair (a registered memory read,
// then a compare), testing float equality and the near window at once. A request
// therefore stays busy through a search over n entries, where n is the search
// position of a hit plus one or the full fill count on a miss (at most
// 2^buffer_bits - 2), then a swap (states SWAPA and SWAPB) of a hit entry one
// place toward the newer end when it is not already newest, then an emit step for each token. Tokens are
// registered, so each one appears the cycle after its emit step; the last token
// is shown in the first idle cycle, when the next request may already be
// accepted. A miss writes the image into the ring at the end of its last emit
// step. The size register is written through the cfg channel only while the
// block is idle and start is low; a write clamps the value to the range
// 2..MAX_BUFFER_BITS and restarts the ring, so no stale entry is ever searched.
// The ring memory itself is never cleared.
module float_history_cache_encoder #(
	parameter int MAX_BUFFER_BITS = fhce_pkg::DEF_MAX_BUFFER_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Request channel.
	input  logic                        start,
	output logic                        busy,
	input  logic [31:0]                 float_image,
	// Configuration channel.
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [fhce_pkg::CFG_W-1:0]  buffer_bits,
	// Token output.
	output logic                        token_strobe,
	output logic [31:0]                 token_value,
	output logic [5:0]                  token_bits,
	output logic                        last
);
	import fhce_pkg::*;

	localparam int MBB   = MAX_BUFFER_BITS;
	localparam int BBW   = $clog2(MAX_BUFFER_BITS + 1);
	localparam int BB_RST = (BUFFER_BITS_RESET > MAX_BUFFER_BITS) ?
		MAX_BUFFER_BITS : BUFFER_BITS_RESET;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_RD    = 3'd1;
	localparam logic [2:0] ST_CMP   = 3'd2;
	localparam logic [2:0] ST_SWAPA = 3'd3;
	localparam logic [2:0] ST_SWAPB = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	// Kind of answer being emitted.
	localparam logic [1:0] KIND_HIT  = 2'd0;
	localparam logic [1:0] KIND_NEAR = 2'd1;
	localparam logic [1:0] KIND_RAW  = 2'd2;

	logic [2:0]      state_q;
	logic [1:0]      kind_q;
	logic [2:0]      k_q;
	logic [BBW-1:0]  bb_q;
	logic [MBB-1:0]  hp_q;
	logic [MBB-1:0]  fill_q;
	logic [MBB-1:0]  i_q;
	logic [MBB-1:0]  pos_q;
	logic [31:0]     image_q;
	logic [31:0]     prev_q;
	logic [31:0]     cur_q;
	logic            near_found_q;
	logic [ZZ_W-1:0] zz_q;

	logic            strobe_q;
	logic [31:0]     value_q;
	logic [5:0]      bits_q;
	logic            last_q;

	logic [MBB-1:0]  mask;
	logic [MBB-1:0]  fill_cap;
	logic [BBW-1:0]  bb_new;
	logic            accept;
	logic            cfg_write;

	logic            mem_we;
	logic [MBB-1:0]  mem_waddr;
	logic [31:0]     mem_wdata;
	logic [MBB-1:0]  mem_raddr;
	logic [31:0]     mem_rdata;
	logic [MBB-1:0]  swap_a;
	logic [MBB-1:0]  swap_b;

	cmp_res_t        cmp;

	logic [31:0]     tok_value;
	logic [5:0]      tok_bits;
	logic            tok_last;
	logic [6:0]      grp;
	logic [ZZ_W-1:0] zz_next;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign accept    = start && !busy;
	assign cfg_write = cfg_valid && cfg_ready;

	// Ring geometry for the current size.
	assign mask     = MBB'((32'd1 << bb_q) - 32'd1);
	assign fill_cap = mask - MBB'(1);

	// Out-of-range sizes are clamped on the write.
	always_comb begin
		if (32'(buffer_bits) < BUFFER_BITS_MIN) begin
			bb_new = BBW'(BUFFER_BITS_MIN);
		end else if (32'(buffer_bits) > MAX_BUFFER_BITS) begin
			bb_new = BBW'(MAX_BUFFER_BITS);
		end else begin
			bb_new = BBW'(buffer_bits);
		end
	end

	// Search position i lives at slot head - 1 - i. A hit swaps with slot + 1.
	assign mem_raddr = (hp_q - MBB'(1) - i_q) & mask;
	assign swap_a    = (hp_q - MBB'(1) - pos_q) & mask;
	assign swap_b    = (swap_a + MBB'(1)) & mask;

	fhce_hist #(
		.AW (MBB)
	) u_hist (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fhce_cmp u_cmp (
		.image (image_q),
		.entry (mem_rdata),
		.res   (cmp)
	);

	// Token generation for the current emit step.
	always_comb begin
		if (zz_q[ZZ_W-1:GRP_W] != '0) begin
			grp = GRP_CONT | {1'b0, zz_q[GRP_W-1:0]};
		end else begin
			grp = zz_q[6:0];
		end
		zz_next = zz_q >> GRP_W;

		tok_value = 32'(pos_q);
		tok_bits  = 6'(bb_q);
		tok_last  = 1'b1;
		case (kind_q)
			KIND_HIT: begin
				tok_value = 32'(pos_q);
			end
			KIND_RAW: begin
				if (k_q == 3'd0) begin
					tok_value = 32'(fill_q) + 32'd1;
					tok_last  = 1'b0;
				end else begin
					tok_value = image_q;
					tok_bits  = RAW_BITS;
				end
			end
			KIND_NEAR: begin
				if (k_q == 3'd0) begin
					tok_value = 32'(fill_q);
					tok_last  = 1'b0;
				end else if (k_q == 3'd1) begin
					tok_value = 32'(pos_q);
					tok_last  = 1'b0;
				end else begin
					tok_value = 32'(grp);
					tok_bits  = GRP_BITS;
					tok_last  = (zz_next == '0);
				end
			end
			default: begin
				tok_value = 32'(pos_q);
			end
		endcase
	end

	// Memory write port: the two halves of a swap, or the push after a miss.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = hp_q & mask;
		mem_wdata = image_q;
		if (state_q == ST_SWAPA) begin
			mem_we    = 1'b1;
			mem_waddr = swap_a;
			mem_wdata = prev_q;
		end else if (state_q == ST_SWAPB) begin
			mem_we    = 1'b1;
			mem_waddr = swap_b;
			mem_wdata = cur_q;
		end else if (state_q == ST_EMIT && tok_last && kind_q != KIND_HIT) begin
			mem_we    = 1'b1;
		end
	end

	// Sequencer and ring pointers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			kind_q       <= KIND_RAW;
			k_q          <= '0;
			bb_q         <= BBW'(BB_RST);
			hp_q         <= '0;
			fill_q       <= '0;
			i_q          <= '0;
			near_found_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_write) begin
						bb_q   <= bb_new;
						hp_q   <= '0;
						fill_q <= '0;
					end
					if (accept) begin
						i_q          <= '0;
						k_q          <= '0;
						near_found_q <= 1'b0;
						if (fill_q == '0) begin
							kind_q  <= KIND_RAW;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (cmp.eq) begin
						kind_q <= KIND_HIT;
						if (i_q != '0) begin
							state_q <= ST_SWAPA;
						end else begin
							state_q <= ST_EMIT;
						end
					end else begin
						if (cmp.near && !near_found_q) begin
							near_found_q <= 1'b1;
						end
						i_q <= i_q + MBB'(1);
						if ((i_q + MBB'(1)) == fill_q) begin
							kind_q  <= (near_found_q || cmp.near) ? KIND_NEAR : KIND_RAW;
							state_q <= ST_EMIT;
						end else begin
							state_q <= ST_RD;
						end
					end
				end
				ST_SWAPA: begin
					state_q <= ST_SWAPB;
				end
				ST_SWAPB: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					k_q <= k_q + 3'd1;
					if (tok_last) begin
						state_q <= ST_IDLE;
						if (kind_q != KIND_HIT) begin
							hp_q <= (hp_q + MBB'(1)) & mask;
							if (fill_q < fill_cap) begin
								fill_q <= fill_q + MBB'(1);
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Search payload: image, neighbor entry for a swap, hit position and delta.
	// prev_q keeps the entry one position newer than the one being compared.
	always_ff @(posedge clk) begin
		if (accept) begin
			image_q <= float_image;
		end
		if (state_q == ST_CMP) begin
			if (cmp.eq) begin
				cur_q <= mem_rdata;
				pos_q <= i_q;
			end else begin
				prev_q <= mem_rdata;
				if (cmp.near && !near_found_q) begin
					pos_q <= i_q;
					zz_q  <= cmp.zz;
				end
			end
		end
		if (state_q == ST_EMIT && kind_q == KIND_NEAR && k_q >= 3'd2) begin
			zz_q <= zz_next;
		end
	end

	// Output register: one token per emit cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT) begin
			value_q <= tok_value;
			bits_q  <= tok_bits;
			last_q  <= tok_last;
		end
	end

	assign token_strobe = strobe_q;
	assign token_value  = value_q;
	assign token_bits   = bits_q;
	assign last         = last_q;

	// A token only follows an emit cycle of the sequencer.
	a_strobe_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		token_strobe |-> ($past(state_q) == ST_EMIT))
		else $error("token strobe without an emit cycle");

	// An accepted request makes the block busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// The fill count never passes two below the ring capacity.
	a_fill_capped: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= fill_cap)
		else $error("fill count exceeds capacity limit");

	// The final token of a request is never directly followed by another.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_strobe && last) |=> !token_strobe)
		else $error("token emitted right after final token");

endmodule
